>>> design/hmc_pkg.sv
// shared types and constants for the hertz / mel scale converter
// no dependencies; imported by every module of the block

package hmc_pkg;

  localparam int unsigned OPERAND_W  = 21;
  localparam int unsigned TDATA_W    = 24;
  localparam int unsigned LOG_STEPS  = 24;
  localparam int unsigned EXP_TERMS  = 13;
  localparam int unsigned LOG_W      = 29;

  localparam logic [20:0] RESULT_MAX = 21'h1FFFFF;

  typedef enum logic {
    OP_HZ_TO_MEL = 1'b0,
    OP_MEL_TO_HZ = 1'b1
  } hmc_op_t;

  // scale constants
  localparam logic [13:0] HTK_BREAK   = 14'd11200;   // 700 hz in 1/16 hz
  localparam logic [13:0] SLN_BREAK_F = 14'd16000;   // 1000 hz in 1/16 hz
  localparam logic [11:0] SLN_BREAK_M = 12'd3840;    // 15 mel in 1/256 mel
  localparam logic [25:0] HTK_MEL_K   = 26'd51194943;
  localparam logic [22:0] HTK_INV_K   = 23'd5498101;
  localparam logic [27:0] SLN_MEL_K   = 28'd169145881;
  localparam logic [28:0] SLN_INV_K   = 29'd426008567;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] Q30_ONE     = 31'h40000000;

  // reciprocals for the linear part of the slaney scale
  localparam logic [21:0] RECIP_25 = 22'((64'd1 << 24) / 25);
  localparam logic [21:0] RECIP_6  = 22'((64'd1 << 24) / 6);

  // log2 in q24, same squaring rule as the hardware, evaluated at elaboration
  function automatic logic [28:0] log2_q24_c(input longint unsigned x);
    longint unsigned y;
    longint unsigned frac;
    longint unsigned p;
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if ((x >> i) != 0) p = longint'(i);
    end
    y = x << (30 - p);
    frac = 0;
    for (int k = 0; k < 24; k++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return 29'((p << 24) | frac);
  endfunction

  localparam logic [28:0] LOG_HTK_BREAK = log2_q24_c(64'd11200);
  localparam logic [28:0] LOG_SLN_BREAK = log2_q24_c(64'd16000);

  // one item in flight through the pipeline
  typedef struct packed {
    logic        op;
    logic        htk;
    logic        lin;       // linear slaney segment, result already known
    logic        oor;       // exponent beyond range
    logic [3:0]  shift;     // integer part of the exponent
    logic [13:0] lin_res;
    logic [4:0]  lg_p;
    logic [30:0] lg_y;
    logic [23:0] lg_frac;
    logic [29:0] ex_x;
    logic [30:0] ex_term;
    logic [31:0] ex_sum;
  } hmc_item_t;

endpackage

>>> design/hz_mel_scale_converter.sv
// top level of the hertz / mel scale converter
// depends on hmc_pkg, hmc_front, hmc_log, hmc_exp, hmc_back

// Converts between frequency (1/16 Hz units) and mel (1/256 mel units) in
// either direction, on the HTK scale (2595*log10(1+f/700)) or the Slaney
// scale (linear below 1000 Hz, logarithmic above), selected by htk_mode.
// The unit is a fully pipelined datapath: one transfer is taken every clock
// while the output is not stalled, and each item passes 3 input stages, 24 log2
// squaring stages, 13 series terms of 3 stages each and 2 output stages.
// Every item passes all stages whichever path it needs, so results leave in
// order. The whole pipeline advances together; it halts only while the
// output register holds a result that has not been taken. Results above
// 2097151 are clamped and flagged in m_tuser. Write htk_mode only while no
// item is in flight.

module hz_mel_scale_converter import hmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,    // htk_mode
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,        // operand [20:0], zero pad above
  input  logic               s_tuser,        // opcode
  // output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,        // result [20:0], zero pad above
  output logic               m_tuser         // saturated
);

  logic        htk_mode;
  logic        en;
  logic        f_vld, l_vld, e_vld;
  hmc_item_t   f_item, l_item, e_item;
  logic [20:0] result;

  // scale select register
  always_ff @(posedge clk) begin
    if (rst) begin
      htk_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      htk_mode <= cfg_wr_data;
    end
  end

  // global advance: move when the output slot is empty or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .in_op      (s_tuser),
    .in_operand (s_tdata[OPERAND_W-1:0]),
    .htk        (htk_mode),
    .out_valid  (f_vld),
    .out_item   (f_item)
  );

  // log2 of the normalized operand (hertz to mel)
  hmc_log u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_vld),
    .in_item   (f_item),
    .out_valid (l_vld),
    .out_item  (l_item)
  );

  // 2^frac series (mel to hertz)
  hmc_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l_vld),
    .in_item   (l_item),
    .out_valid (e_vld),
    .out_item  (e_item)
  );

  hmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_vld),
    .in_item   (e_item),
    .out_valid (m_tvalid),
    .result    (result),
    .saturated (m_tuser)
  );

  assign m_tdata = {3'b0, result};

endmodule

>>> design/hmc_front.sv
// input stages: operand decode, exponent product, log normalize, linear segment
// depends on hmc_pkg

module hmc_front import hmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_op,
  input  logic [OPERAND_W-1:0] in_operand,
  input  logic                 htk,
  output logic                 out_valid,
  output hmc_item_t            out_item
);

  // stage 1
  logic        vld1;
  logic        op1, htk1, lin1;
  logic [21:0] lx1;
  logic [49:0] tprod1;
  logic [16:0] num1;

  logic [21:0] lx_c;
  logic [20:0] mop_c;
  logic [28:0] mk_c;
  logic [16:0] num_c;
  logic        lin_c;

  always_comb begin
    lx_c  = htk ? 22'(in_operand) + 22'(HTK_BREAK) : 22'(in_operand);
    mop_c = htk ? in_operand : in_operand - 21'(SLN_BREAK_M);
    mk_c  = htk ? 29'(HTK_INV_K) : SLN_INV_K;
    num_c = (in_op == OP_MEL_TO_HZ) ? 17'(in_operand[11:0]) * 17'd25 + 17'd3
                                    : 17'(in_operand[13:0]) * 17'd6 + 17'd12;
    lin_c = !htk && ((in_op == OP_MEL_TO_HZ) ? (in_operand < 21'(SLN_BREAK_M))
                                             : (in_operand < 21'(SLN_BREAK_F)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
    end
    if (en) begin
      op1    <= in_op;
      htk1   <= htk;
      lin1   <= lin_c;
      lx1    <= lx_c;
      tprod1 <= 50'(mop_c) * 50'(mk_c);
      num1   <= num_c;
    end
  end

  // stage 2
  logic        vld2;
  logic        op2, htk2, lin2, oor2;
  logic [3:0]  n2;
  logic [4:0]  p2;
  logic [30:0] y2;
  logic [23:0] f2;
  logic [38:0] qm2;
  logic [16:0] num2;

  logic [4:0]  p_c;
  logic [49:0] tsum_c;
  logic [33:0] t_c;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 22; i++) begin
      if (lx1[i]) p_c = 5'(i);
    end
    tsum_c = tprod1 + (50'd1 << 15);
    t_c    = tsum_c[49:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
    if (en) begin
      op2  <= op1;
      htk2 <= htk1;
      lin2 <= lin1;
      p2   <= p_c;
      y2   <= {9'b0, lx1} << (5'd30 - p_c);
      f2   <= t_c[23:0];
      n2   <= t_c[27:24];
      oor2 <= (|t_c[33:28]) || (t_c[27:24] >= 4'd12);
      qm2  <= 39'(num1) * 39'((op1 == OP_MEL_TO_HZ) ? RECIP_6 : RECIP_25);
      num2 <= num1;
    end
  end

  // stage 3: ln2 scaling of the fraction, linear quotient correction
  logic [53:0] xp_c;
  logic [14:0] qe_c;
  logic [4:0]  d_c;
  logic [16:0] r_c;
  hmc_item_t   item_c;

  always_comb begin
    xp_c = 54'(f2) * 54'(LN2_Q30);
    qe_c = qm2[38:24];
    d_c  = (op2 == OP_MEL_TO_HZ) ? 5'd6 : 5'd25;
    r_c  = num2 - 17'(20'(qe_c) * 20'(d_c));
    item_c          = '0;
    item_c.op       = op2;
    item_c.htk      = htk2;
    item_c.lin      = lin2;
    item_c.oor      = oor2;
    item_c.shift    = n2;
    item_c.lin_res  = 14'(qe_c + 15'(r_c >= 17'(d_c)));
    item_c.lg_p     = p2;
    item_c.lg_y     = y2;
    item_c.lg_frac  = '0;
    item_c.ex_x     = xp_c[53:24];
    item_c.ex_term  = Q30_ONE;
    item_c.ex_sum   = 32'(Q30_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld2;
    end
    if (en) begin
      out_item <= item_c;
    end
  end

endmodule

>>> design/hmc_log.sv
// log2 pipeline: one squaring step per stage yields one fraction bit
// depends on hmc_pkg

module hmc_log import hmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  hmc_item_t in_item,
  output logic      out_valid,
  output hmc_item_t out_item
);

  hmc_item_t st   [0:LOG_STEPS];
  logic      vld  [0:LOG_STEPS];

  assign st[0]     = in_item;
  assign vld[0]    = in_valid;
  assign out_item  = st[LOG_STEPS];
  assign out_valid = vld[LOG_STEPS];

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_step
    logic [61:0] sq;
    logic [31:0] sh;
    hmc_item_t   nxt;

    always_comb begin
      sq  = 62'(st[g].lg_y) * 62'(st[g].lg_y);
      sh  = sq[61:30];
      nxt = st[g];
      if (sh[31]) begin
        nxt.lg_y = sh[31:1];
      end else begin
        nxt.lg_y = sh[30:0];
      end
      nxt.lg_frac = {st[g].lg_frac[22:0], sh[31]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        st[g+1] <= nxt;
      end
    end
  end

endmodule

>>> design/hmc_exp.sv
// 2^f series pipeline: three stages per taylor term (product, reciprocal, fix-up)
// depends on hmc_pkg

module hmc_exp import hmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  hmc_item_t in_item,
  output logic      out_valid,
  output hmc_item_t out_item
);

  hmc_item_t st  [0:EXP_TERMS];
  logic      vld [0:EXP_TERMS];

  assign st[0]     = in_item;
  assign vld[0]    = in_valid;
  assign out_item  = st[EXP_TERMS];
  assign out_valid = vld[EXP_TERMS];

  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_term
    localparam logic [3:0]  K     = 4'(g + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / (g + 1));

    logic [60:0] tx;
    logic        a_vld, b_vld;
    hmc_item_t   a_item, b_item;
    logic [29:0] a_v, b_v;
    logic [61:0] b_qm;
    logic [30:0] qe;
    logic [34:0] r;
    logic [30:0] q;
    hmc_item_t   nxt;

    always_comb begin
      tx  = 61'(st[g].ex_term) * 61'(st[g].ex_x);
      qe  = b_qm[61:31];
      r   = 35'(b_v) - 35'(qe) * 35'(K);
      q   = qe + 31'(r >= 35'(K));
      nxt = b_item;
      nxt.ex_term = q;
      nxt.ex_sum  = b_item.ex_sum + 32'(q);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld    <= 1'b0;
        b_vld    <= 1'b0;
        vld[g+1] <= 1'b0;
      end else if (en) begin
        a_vld    <= vld[g];
        b_vld    <= a_vld;
        vld[g+1] <= b_vld;
      end
      if (en) begin
        a_item  <= st[g];
        a_v     <= tx[59:30];
        b_item  <= a_item;
        b_v     <= a_v;
        b_qm    <= 62'(a_v) * 62'(RECIP);
        st[g+1] <= nxt;
      end
    end
  end

endmodule

>>> design/hmc_back.sv
// output stages: final scaling product, rounding, offset and saturation
// depends on hmc_pkg

module hmc_back import hmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  hmc_item_t   in_item,
  output logic        out_valid,
  output logic [20:0] result,
  output logic        saturated
);

  // stage 1: one shared multiplier, mel scaling or c * 2^f
  logic        vld1;
  logic        op1, htk1, lin1, oor1;
  logic [3:0]  n1;
  logic [13:0] lin_res1;
  logic [60:0] prod1;

  logic [28:0] d_c;
  logic [28:0] a_c;
  logic [31:0] b_c;

  always_comb begin
    d_c = {in_item.lg_p[4:0], in_item.lg_frac}
        - (in_item.htk ? LOG_HTK_BREAK : LOG_SLN_BREAK);
    if (in_item.op == OP_MEL_TO_HZ) begin
      a_c = 29'(in_item.htk ? HTK_BREAK : SLN_BREAK_F);
      b_c = in_item.ex_sum;
    end else begin
      a_c = d_c;
      b_c = in_item.htk ? 32'(HTK_MEL_K) : 32'(SLN_MEL_K);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
    end
    if (en) begin
      op1      <= in_item.op;
      htk1     <= in_item.htk;
      lin1     <= in_item.lin;
      oor1     <= in_item.oor;
      n1       <= in_item.shift;
      lin_res1 <= in_item.lin_res;
      prod1    <= 61'(a_c) * 61'(b_c);
    end
  end

  // stage 2: round, offset, clamp
  logic [61:0] mh_c, ms_c;
  logic [71:0] sh_c, sr_c;
  logic [41:0] rnd_c;
  logic [42:0] val_c;
  logic        sat_c;

  always_comb begin
    mh_c  = 62'(prod1) + (62'd1 << 31);
    ms_c  = 62'(prod1) + (62'd1 << 39);
    sh_c  = 72'(prod1) << n1;
    sr_c  = sh_c + (72'd1 << 29);
    rnd_c = sr_c[71:30];
    sat_c = 1'b0;
    if (lin1) begin
      val_c = 43'(lin_res1);
    end else if (op1 == OP_HZ_TO_MEL) begin
      val_c = htk1 ? 43'(mh_c[61:32]) : 43'(ms_c[61:40]) + 43'(SLN_BREAK_M);
    end else if (oor1) begin
      val_c = 43'(RESULT_MAX);
      sat_c = 1'b1;
    end else if (htk1) begin
      val_c = (rnd_c >= 42'(HTK_BREAK)) ? 43'(rnd_c - 42'(HTK_BREAK)) : '0;
    end else begin
      val_c = 43'(rnd_c);
    end
    if (val_c > 43'(RESULT_MAX)) begin
      val_c = 43'(RESULT_MAX);
      sat_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld1;
    end
    if (en) begin
      result    <= val_c[20:0];
      saturated <= sat_c;
    end
  end

endmodule
